@@ rtl/fqrv_pkg.sv @@
// Shared types and codes for the FIFO queue with remove-by-value.
// Used by fqrv_cell and fifo_queue_with_remove_by_value; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package fqrv_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // Operation codes on the mode field
    localparam logic [2:0] MODE_PUSH   = 3'd0;
    localparam logic [2:0] MODE_LIST   = 3'd1;
    localparam logic [2:0] MODE_POP    = 3'd2;
    localparam logic [2:0] MODE_CLEAR  = 3'd3;
    localparam logic [2:0] MODE_REMOVE = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_LISTED   = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        CMD_HOLD,
        CMD_PUSH,
        CMD_SHIFT,
        CMD_REMOVE,
        CMD_ROTATE
    } cell_cmd_t;

    // Control handed from the top level to one cell
    typedef struct packed {
        cell_cmd_t cmd;
        logic      at_fill;   // this cell is the first free slot
        logic      at_tail;   // this cell holds the newest value
        logic      occupied;  // this cell holds a stored value
    } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/fqrv_cell.sv @@
// One storage cell of the shifting queue: holds a value, takes its right
// neighbor on a shift, and extends the first-match chain. Uses fqrv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fqrv_cell #(
    parameter int DATA_WIDTH = fqrv_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire                        aclk,
    input  fqrv_pkg::cell_ctrl_t       ctrl,
    input  wire logic [DATA_WIDTH-1:0] value,
    input  wire logic [DATA_WIDTH-1:0] head_data,
    input  wire logic [DATA_WIDTH-1:0] right_data,
    input  wire logic                  match_in,
    output logic                       match_out,
    output logic [DATA_WIDTH-1:0]      data
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic                  hit;

    assign hit       = ctrl.occupied && (data_reg == value);
    assign match_out = match_in || hit;
    assign data      = data_reg;

    always_comb begin
        data_next = data_reg;
        case (ctrl.cmd)
            fqrv_pkg::CMD_PUSH: begin
                if (ctrl.at_fill) data_next = value;
            end
            fqrv_pkg::CMD_SHIFT: begin
                data_next = right_data;
            end
            fqrv_pkg::CMD_REMOVE: begin
                // close the gap from the first match onward
                if (match_out) data_next = right_data;
            end
            fqrv_pkg::CMD_ROTATE: begin
                data_next = ctrl.at_tail ? head_data : right_data;
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule
`default_nettype wire

@@ rtl/fifo_queue_with_remove_by_value.sv @@
// Top level of the FIFO queue with remove-by-value: a row of fqrv_cell
// instances plus the control sequencer. Uses fqrv_pkg and fqrv_cell.
`timescale 1ns / 1ps
`default_nettype none
// Bounded FIFO of DEPTH signed values held in a row of shifting cells; cell 0
// always holds the oldest value. Each input transfer carries a mode and a
// value: push appends (status full when DEPTH values are stored), pop returns
// the oldest, clear empties the queue, remove deletes the oldest entry equal
// to the value and closes the gap (status not found otherwise), and list
// returns every stored value oldest first with last set on the final one, or
// a single empty result. Push, pop, clear, remove and unused modes each
// produce one result transfer; list produces one result per stored element,
// one per cycle while m_ready keeps the output register free, because the row
// rotates by one cell each time cell 0 is copied to the output register; the
// input side is held off until the last listed element has been loaded. Every
// result goes through a single output register, so a new input transfer can be
// taken in the same cycle as the previous result. Values are DATA_WIDTH bits
// wide: the low DATA_WIDTH bits of s_value are stored and compared, and
// m_element is the stored value sign-extended (or truncated) to 32 bits.
module fifo_queue_with_remove_by_value #(
    parameter int DEPTH      = fqrv_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = fqrv_pkg::DATA_WIDTH_DEFAULT
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire logic [2:0]    s_mode,
    input  wire logic [31:0]   s_value,
    output logic               m_valid,
    input  wire                m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_element,
    output logic               m_last
);

    localparam int FW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t         state_reg, state_next;
    logic [FW-1:0]  fill_reg, fill_next;
    logic [FW-1:0]  rem_reg, rem_next;     // listed elements still to load
    logic           m_valid_reg, m_valid_next;
    logic [2:0]     m_status_reg, m_status_next;
    logic [31:0]    m_element_reg, m_element_next;
    logic           m_last_reg, m_last_next;

    fqrv_pkg::cell_cmd_t   cmd;
    logic [DATA_WIDTH-1:0] in_val;
    logic [31:0]           head_elem;
    logic                  out_free;
    logic                  full;
    logic                  found;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];
    logic [DEPTH:0]        match_chain;

    // Take the low DATA_WIDTH bits of the input value, zero-filled above 32
    always_comb begin
        in_val = '0;
        for (int b = 0; b < DATA_WIDTH; b++) begin
            if (b < 32) in_val[b] = s_value[b];
        end
    end

    // Sign-extend or truncate the oldest value to the 32-bit element field
    always_comb begin
        for (int b = 0; b < 32; b++) begin
            head_elem[b] = (b < DATA_WIDTH) ? cell_data[0][b] : cell_data[0][DATA_WIDTH-1];
        end
    end

    // Row of cells; the first-match chain runs from the oldest cell onward
    assign match_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        fqrv_pkg::cell_ctrl_t  ctrl;
        logic [DATA_WIDTH-1:0] right;

        assign ctrl.cmd      = cmd;
        assign ctrl.at_fill  = (fill_reg == FW'(i));
        assign ctrl.at_tail  = (fill_reg == FW'(i + 1));
        assign ctrl.occupied = (FW'(i) < fill_reg);

        if (i == DEPTH - 1) begin : g_end
            assign right = cell_data[i];
        end else begin : g_mid
            assign right = cell_data[i+1];
        end

        fqrv_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .value     (in_val),
            .head_data (cell_data[0]),
            .right_data(right),
            .match_in  (match_chain[i]),
            .match_out (match_chain[i+1]),
            .data      (cell_data[i])
        );
    end

    assign found    = match_chain[DEPTH];
    assign full     = (fill_reg == FW'(DEPTH));
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        rem_next       = rem_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_element_next = m_element_reg;
        m_last_next    = m_last_reg;
        cmd            = fqrv_pkg::CMD_HOLD;

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    m_valid_next   = 1'b1;
                    m_last_next    = 1'b1;
                    m_status_next  = fqrv_pkg::ST_DONE;
                    m_element_next = '0;
                    case (s_mode)
                        fqrv_pkg::MODE_PUSH: begin
                            if (full) begin
                                m_status_next = fqrv_pkg::ST_FULL;
                            end else begin
                                cmd       = fqrv_pkg::CMD_PUSH;
                                fill_next = fill_reg + FW'(1);
                            end
                        end
                        fqrv_pkg::MODE_LIST: begin
                            if (fill_reg == '0) begin
                                m_status_next = fqrv_pkg::ST_EMPTY;
                            end else begin
                                // emit the oldest and rotate the row by one
                                m_status_next  = fqrv_pkg::ST_LISTED;
                                m_element_next = head_elem;
                                m_last_next    = (fill_reg == FW'(1));
                                cmd            = fqrv_pkg::CMD_ROTATE;
                                rem_next       = fill_reg - FW'(1);
                                if (fill_reg != FW'(1)) state_next = S_LIST;
                            end
                        end
                        fqrv_pkg::MODE_POP: begin
                            if (fill_reg == '0) begin
                                m_status_next = fqrv_pkg::ST_EMPTY;
                            end else begin
                                m_element_next = head_elem;
                                cmd            = fqrv_pkg::CMD_SHIFT;
                                fill_next      = fill_reg - FW'(1);
                            end
                        end
                        fqrv_pkg::MODE_CLEAR: begin
                            fill_next = '0;
                        end
                        fqrv_pkg::MODE_REMOVE: begin
                            if (found) begin
                                cmd       = fqrv_pkg::CMD_REMOVE;
                                fill_next = fill_reg - FW'(1);
                            end else begin
                                m_status_next = fqrv_pkg::ST_NOTFOUND;
                            end
                        end
                        default: begin
                            // unused mode: leave the queue as it is
                        end
                    endcase
                end
            end
            S_LIST: begin
                // load the next element once the output register frees up
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_status_next  = fqrv_pkg::ST_LISTED;
                    m_element_next = head_elem;
                    m_last_next    = (rem_reg == FW'(1));
                    cmd            = fqrv_pkg::CMD_ROTATE;
                    rem_next       = rem_reg - FW'(1);
                    if (rem_reg == FW'(1)) state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fill_reg    <= '0;
            rem_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            rem_reg     <= rem_next;
            m_valid_reg <= m_valid_next;
        end
        m_status_reg  <= m_status_next;
        m_element_reg <= m_element_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = m_status_reg;
    assign m_element = m_element_reg;
    assign m_last    = m_last_reg;

    // Fill count never exceeds the row length
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(DEPTH))
        else $error("fill count beyond depth");

    // While listing, a listed element always waits in the output register
    a_list_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |-> m_valid_reg)
        else $error("listing with an empty output register");

    // While listing, the remaining count stays inside the fill count
    a_list_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |-> (rem_reg != '0 && rem_reg < fill_reg))
        else $error("list count out of range");

    // A push into a full queue leaves the fill count unchanged
    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_mode == fqrv_pkg::MODE_PUSH && full)
            |=> $stable(fill_reg))
        else $error("push into full queue changed the fill count");

    // Listing rotates the row and never changes the fill count
    a_list_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_LIST) |=> $stable(fill_reg))
        else $error("fill count changed while listing");

endmodule
`default_nettype wire
